// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/smm_pkg.sv -----
// Package with request and result types and command and status codes.
package smm_pkg;
  localparam logic [2:0] CMD_MAP = 3'd0;
  localparam logic [2:0] CMD_UNMAP = 3'd1;
  localparam logic [2:0] CMD_LOAD = 3'd2;
  localparam logic [2:0] CMD_STORE = 3'd3;
  localparam logic [2:0] CMD_LDPROG = 3'd4;
  localparam logic [2:0] CMD_FETCH = 3'd5;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADSEG = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;
  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  segment_id;
    logic [7:0]  offset;
    logic [31:0] word_value;
    logic [8:0]  seg_size;
  } req_t;
  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
  } res_t;
endpackage

// ----- rtl/segmented_memory_manager.sv -----
// Top level: command sequencer around the word store and segment tables.
//  channel | direction | payload         | handshake
//  req     | in        | smm_pkg::req_t  | req_valid / req_stall
//  res     | out       | smm_pkg::res_t  | res_valid / res_stall
// Unmap, store, unknown commands and every error go through S_EXEC alone;
// load and fetch add S_READ, as the word RAM read is registered. Map adds S_FILL
// (one zero write a cycle, a single write for size zero), load program S_CPRD
// and S_CPWR for each word (read then write per word, on the same port).
// Reset is synchronous; segment 0 is full and mapped, the rest unmapped.
// A request waits while the result register is full and stalled.
module segmented_memory_manager #(
  parameter int NUM_SEGMENTS = 64,
  parameter int SEGMENT_WORDS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  smm_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output smm_pkg::res_t res
);
  localparam int SW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int WW = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
  localparam int LW = $clog2(SEGMENT_WORDS + 1);
  localparam int CW = $clog2(NUM_SEGMENTS + 1);
  localparam int AW = SW + WW;
  localparam int PW = (LW > 9) ? LW : 9;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_EXEC = 6'b000010, S_READ = 6'b000100,
    S_FILL = 6'b001000, S_CPRD = 6'b010000, S_CPWR = 6'b100000
  } state_t;
  state_t state;

  logic [LW-1:0] seg_len [0:NUM_SEGMENTS-1];
  logic [LW-1:0] len_rd, len0, len_eff;
  logic [NUM_SEGMENTS-1:0] mapped;
  logic [SW-1:0] fq [0:NUM_SEGMENTS-1];
  logic [SW-1:0] fq_rd;
  logic [SW-1:0] head, tail;
  logic [CW-1:0] fcount, issued;
  logic [PW-1:0] pc;
  smm_pkg::req_t r;
  logic [SW-1:0] sid, req_sid;
  logic [LW-1:0] len_q, cnt;
  logic idx_fit, idx_ok;
  logic [SW-1:0] nid;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_wd, ram_rd;
  logic out_free;

  assign out_free = !res_valid || !res_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  // Identifiers beyond the segment count are bad whatever the width.
  assign sid = SW'(r.segment_id);
  assign req_sid = SW'(req.segment_id);
  assign idx_fit = (32'(r.segment_id) < NUM_SEGMENTS) && mapped[sid];
  // Segment 0's length lives in a register, so the table needs no reset.
  assign len_eff = (sid == '0) ? len0 : len_rd;
  assign idx_ok = 32'(r.offset) < 32'(len_eff);

  smm_word_ram #(.AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_wd = r.word_value;
    ram_addr = {sid, WW'(r.offset)};
    case (state)
      S_EXEC: begin
        if (r.cmd == smm_pkg::CMD_STORE && idx_fit && idx_ok) ram_we = 1'b1;
        if (r.cmd == smm_pkg::CMD_FETCH) ram_addr = {SW'(0), WW'(pc)};
      end
      S_FILL: begin
        ram_we = 1'b1;
        ram_wd = '0;
        ram_addr = {nid, WW'(cnt)};
      end
      S_CPRD: ram_addr = {sid, WW'(cnt)};
      S_CPWR: begin
        ram_we = 1'b1;
        ram_wd = ram_rd;
        ram_addr = {SW'(0), WW'(cnt)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    fq_rd <= fq[head];
    if (state == S_IDLE) len_rd <= seg_len[req_sid];
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      mapped <= NUM_SEGMENTS'(1);
      len0 <= LW'(SEGMENT_WORDS);
      head <= '0;
      tail <= '0;
      fcount <= '0;
      issued <= CW'(1);
      pc <= '0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid && out_free) begin
            r <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res.data_out <= '0;
          res.status <= smm_pkg::ST_OK;
          state <= S_IDLE;
          res_valid <= 1'b1;
          case (r.cmd)
            smm_pkg::CMD_MAP: begin
              if (32'(r.seg_size) > SEGMENT_WORDS) res.status <= smm_pkg::ST_RANGE;
              else if (fcount == '0 && 32'(issued) >= NUM_SEGMENTS)
                res.status <= smm_pkg::ST_FULL;
              else begin
                if (fcount != '0) begin
                  nid <= fq_rd;
                  head <= (32'(head) + 1 >= NUM_SEGMENTS) ? '0 : head + 1'b1;
                  fcount <= fcount - 1'b1;
                end else begin
                  nid <= issued[SW-1:0];
                  issued <= issued + 1'b1;
                end
                len_q <= LW'(r.seg_size);
                cnt <= '0;
                res_valid <= 1'b0;
                state <= S_FILL;
              end
            end
            smm_pkg::CMD_UNMAP: begin
              if (r.segment_id == '0 || !idx_fit) res.status <= smm_pkg::ST_BADSEG;
              else if (32'(fcount) >= NUM_SEGMENTS) res.status <= smm_pkg::ST_FULL;
              else begin
                fq[tail] <= sid;
                tail <= (32'(tail) + 1 >= NUM_SEGMENTS) ? '0 : tail + 1'b1;
                fcount <= fcount + 1'b1;
                mapped[sid] <= 1'b0;
                seg_len[sid] <= '0;
              end
            end
            smm_pkg::CMD_LOAD, smm_pkg::CMD_STORE: begin
              if (!idx_fit) res.status <= smm_pkg::ST_BADSEG;
              else if (!idx_ok) res.status <= smm_pkg::ST_RANGE;
              else if (r.cmd == smm_pkg::CMD_LOAD) begin
                res_valid <= 1'b0;
                state <= S_READ;
              end
            end
            smm_pkg::CMD_LDPROG: begin
              if (!idx_fit) res.status <= smm_pkg::ST_BADSEG;
              else begin
                pc <= PW'(r.offset);
                if (sid != '0) begin
                  len_q <= len_rd;
                  len0 <= len_rd;
                  cnt <= '0;
                  if (len_rd != '0) begin
                    res_valid <= 1'b0;
                    state <= S_CPRD;
                  end
                end
              end
            end
            smm_pkg::CMD_FETCH: begin
              if (32'(pc) >= 32'(len0))
                res.status <= smm_pkg::ST_RANGE;
              else begin
                pc <= pc + 1'b1;
                res_valid <= 1'b0;
                state <= S_READ;
              end
            end
            default: ;
          endcase
        end
        S_READ: begin
          res.data_out <= ram_rd;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_FILL: begin
          // The address is written even for size zero; the entry is not readable.
          if (cnt + 1'b1 >= len_q) begin
            seg_len[nid] <= len_q;
            mapped[nid] <= 1'b1;
            res.data_out <= 32'(nid);
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
          cnt <= cnt + 1'b1;
        end
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          state <= S_CPRD;
          if (cnt + 1'b1 >= len_q) begin
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
          cnt <= cnt + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_seg0_mapped, clk, rst, 1'b1, mapped[0], "segment 0 unmapped")
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, 32'(fcount) < NUM_SEGMENTS, "queue overflow")
  `ASSERT_NEXT(a_res_holds, clk, rst, res_valid && res_stall, res_valid && $stable(res),
               "stalled result changed")
endmodule

// ----- rtl/smm_word_ram.sv -----
// Word store: single-port synchronous RAM with registered read.
module smm_word_ram #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  logic [31:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- bench/smm_checker.sv -----
// Request and result monitor with a prediction of the segmented memory and in-order checking.
module smm_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  smm_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_stall,
  input  smm_pkg::res_t res,
  output int            fails,
  output int            outstanding,
  output int            checked
);
  localparam int SEGS = 64;
  localparam int WORDS = 256;

  logic [31:0] words [0:SEGS*WORDS-1];
  logic [8:0]  seg_len [SEGS];
  bit          seg_live [SEGS];
  logic [5:0]  free_ids [SEGS];
  logic [5:0]  free_head, free_tail;
  logic [6:0]  free_count, issued;
  logic [8:0]  pc;
  smm_pkg::res_t expected_q [$];

  // Applies one request to the predicted state and returns the result it should give.
  function automatic smm_pkg::res_t predict(smm_pkg::req_t r);
    smm_pkg::res_t o;
    logic [5:0] nid;
    o = '0;
    o.status = smm_pkg::ST_OK;
    case (r.cmd)
      smm_pkg::CMD_MAP: begin
        if (r.seg_size > WORDS) o.status = smm_pkg::ST_RANGE;
        else if (free_count == 0 && issued >= SEGS) o.status = smm_pkg::ST_FULL;
        else begin
          if (free_count > 0) begin
            nid = free_ids[free_head];
            free_head++;
            free_count--;
          end else begin
            nid = issued[5:0];
            issued++;
          end
          for (int k = 0; k < r.seg_size; k++) words[{nid, 8'(k)}] = '0;
          seg_len[nid] = r.seg_size;
          seg_live[nid] = 1;
          o.data_out = 32'(nid);
        end
      end
      smm_pkg::CMD_UNMAP: begin
        if (r.segment_id == 0 || !seg_live[r.segment_id]) o.status = smm_pkg::ST_BADSEG;
        else if (free_count >= SEGS) o.status = smm_pkg::ST_FULL;
        else begin
          free_ids[free_tail] = r.segment_id;
          free_tail++;
          free_count++;
          seg_live[r.segment_id] = 0;
          seg_len[r.segment_id] = '0;
        end
      end
      smm_pkg::CMD_LOAD: begin
        if (!seg_live[r.segment_id]) o.status = smm_pkg::ST_BADSEG;
        else if (r.offset >= seg_len[r.segment_id]) o.status = smm_pkg::ST_RANGE;
        else o.data_out = words[{r.segment_id, r.offset}];
      end
      smm_pkg::CMD_STORE: begin
        if (!seg_live[r.segment_id]) o.status = smm_pkg::ST_BADSEG;
        else if (r.offset >= seg_len[r.segment_id]) o.status = smm_pkg::ST_RANGE;
        else words[{r.segment_id, r.offset}] = r.word_value;
      end
      smm_pkg::CMD_LDPROG: begin
        if (!seg_live[r.segment_id]) o.status = smm_pkg::ST_BADSEG;
        else begin
          if (r.segment_id != 0) begin
            for (int k = 0; k < seg_len[r.segment_id]; k++)
              words[{6'd0, 8'(k)}] = words[{r.segment_id, 8'(k)}];
            seg_len[0] = seg_len[r.segment_id];
          end
          pc = {1'b0, r.offset};
        end
      end
      smm_pkg::CMD_FETCH: begin
        if (pc >= seg_len[0]) o.status = smm_pkg::ST_RANGE;
        else begin
          o.data_out = words[{6'd0, pc[7:0]}];
          pc++;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    smm_pkg::res_t want;
    if (rst) begin
      for (int k = 0; k < SEGS; k++) begin
        seg_len[k] = '0;
        seg_live[k] = 0;
      end
      seg_len[0] = 9'(WORDS);
      seg_live[0] = 1;
      free_head = '0;
      free_tail = '0;
      free_count = '0;
      issued = 7'd1;
      pc = '0;
      expected_q.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (req_valid && !req_stall) expected_q.push_back(predict(req));
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected: data %h status %0d",
                   $time, res.data_out, res.status);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (res.data_out !== want.data_out) begin
            fails++;
            $display("%0t: data_out mismatch: expected %h, got %h",
                     $time, want.data_out, res.data_out);
          end
          if (res.status !== want.status) begin
            fails++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, res.status);
          end
        end
      end
    end
    outstanding = expected_q.size();
  end
endmodule

// ----- bench/tb_top.sv -----
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the segmented memory.
module tb_top;
  localparam int RANDOM_ITEMS = 1150;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic res_stall = 0;
  smm_pkg::req_t req = '0;
  logic req_stall, res_valid;
  smm_pkg::res_t res;
  int   fails, outstanding, checked;
  int   idle_cycles = 0;
  int   n_directed = 0;
  int   n_sent = 0;

  // Stimulus-side view of the memory, so that no word is read before it is written.
  bit pl_map [64];
  int pl_len [64];
  bit pl_def [64][256];
  int pl_free [$];
  int pl_issued = 1;
  int pl_pc = 0;

  segmented_memory_manager dut (.*);

  smm_checker chk (
    .clk, .rst, .req_valid, .req_stall, .req, .res_valid, .res_stall, .res,
    .fails, .outstanding, .checked
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic smm_pkg::req_t cmd_item(logic [2:0] c, int id, int idx, logic [31:0] v,
                                             int sz);
    smm_pkg::req_t r;
    r.cmd = c;
    r.segment_id = 6'(id);
    r.offset = 8'(idx);
    r.word_value = v;
    r.seg_size = 9'(sz);
    return r;
  endfunction

  // A read of an unwritten word is turned into a store to it, then the view is updated.
  function automatic void plan_apply(inout smm_pkg::req_t r);
    int s, i, n;
    s = r.segment_id;
    i = r.offset;
    if (r.cmd == smm_pkg::CMD_LOAD && pl_map[s] && i < pl_len[s] && !pl_def[s][i])
      r.cmd = smm_pkg::CMD_STORE;
    if (r.cmd == smm_pkg::CMD_FETCH && pl_pc < pl_len[0] && !pl_def[0][pl_pc]) begin
      r.cmd = smm_pkg::CMD_STORE;
      r.segment_id = '0;
      r.offset = 8'(pl_pc);
      s = 0;
      i = pl_pc;
    end
    case (r.cmd)
      smm_pkg::CMD_MAP: if (r.seg_size <= 256) begin
        n = -1;
        if (pl_free.size() > 0) n = pl_free.pop_front();
        else if (pl_issued < 64) begin
          n = pl_issued;
          pl_issued++;
        end
        if (n >= 0) begin
          pl_map[n] = 1;
          pl_len[n] = r.seg_size;
          for (int k = 0; k < 256; k++) pl_def[n][k] = (k < r.seg_size);
        end
      end
      smm_pkg::CMD_UNMAP: if (s != 0 && pl_map[s]) begin
        pl_map[s] = 0;
        pl_len[s] = 0;
        pl_free.push_back(s);
      end
      smm_pkg::CMD_STORE: if (pl_map[s] && i < pl_len[s]) pl_def[s][i] = 1;
      smm_pkg::CMD_LDPROG: if (pl_map[s]) begin
        if (s != 0) begin
          for (int k = 0; k < pl_len[s]; k++) pl_def[0][k] = pl_def[s][k];
          pl_len[0] = pl_len[s];
        end
        pl_pc = i;
      end
      smm_pkg::CMD_FETCH: if (pl_pc < pl_len[0]) pl_pc++;
      default: ;
    endcase
  endfunction

  function automatic smm_pkg::req_t rand_request(bit exhaust);
    smm_pkg::req_t r;
    int p, q;
    int ids [$];
    r = cmd_item(smm_pkg::CMD_MAP, $urandom, $urandom, $urandom, $urandom_range(0, 16));
    if (exhaust) begin
      r.seg_size = 9'($urandom_range(0, 2));
      return r;
    end
    for (int k = 0; k < 64; k++) if (pl_map[k]) ids.push_back(k);
    p = $urandom_range(0, 99);
    if (p < 14) begin
      q = $urandom_range(0, 19);
      if (q == 0) r.seg_size = 9'd256;
      else if (q == 1) r.seg_size = 9'($urandom_range(257, 511));
    end
    else if (p < 26) r.cmd = smm_pkg::CMD_UNMAP;
    else if (p < 50) r.cmd = smm_pkg::CMD_LOAD;
    else if (p < 74) r.cmd = smm_pkg::CMD_STORE;
    else if (p < 80) r.cmd = smm_pkg::CMD_LDPROG;
    else if (p < 98) r.cmd = smm_pkg::CMD_FETCH;
    else r.cmd = 3'($urandom_range(6, 7));
    if (r.cmd inside {smm_pkg::CMD_UNMAP, smm_pkg::CMD_LOAD, smm_pkg::CMD_STORE,
                      smm_pkg::CMD_LDPROG} &&
        $urandom_range(0, 9) != 0) begin
      r.segment_id = 6'(ids[$urandom_range(0, ids.size() - 1)]);
      if (pl_len[r.segment_id] > 0 && $urandom_range(0, 7) != 0)
        r.offset = 8'($urandom_range(0, pl_len[r.segment_id] - 1));
    end
    if (r.cmd == smm_pkg::CMD_LDPROG && $urandom_range(0, 3) != 0)
      r.offset = 8'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic send(smm_pkg::req_t r);
    int g, p;
    plan_apply(r);
    req <= r;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    n_sent++;
    p = $urandom_range(0, 99);
    if ((n_sent / 150) % 3 == 0 || p < 60) g = 0;
    else if (p < 92) g = $urandom_range(1, 3);
    else g = $urandom_range(8, 30);
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    smm_pkg::req_t directed [$];
    pl_map[0] = 1;
    pl_len[0] = 256;
    directed = '{
      cmd_item(smm_pkg::CMD_MAP, 0, 0, 0, 0),
      cmd_item(smm_pkg::CMD_MAP, 0, 0, 0, 256),
      cmd_item(smm_pkg::CMD_MAP, 0, 0, 0, 257),
      cmd_item(smm_pkg::CMD_MAP, 63, 255, 32'hffff_ffff, 511),
      cmd_item(smm_pkg::CMD_STORE, 2, 0, 32'h0, 0),
      cmd_item(smm_pkg::CMD_STORE, 2, 255, 32'hffff_ffff, 0),
      cmd_item(smm_pkg::CMD_LOAD, 2, 255, 0, 0),
      cmd_item(smm_pkg::CMD_LOAD, 2, 0, 0, 0),
      cmd_item(smm_pkg::CMD_LOAD, 1, 0, 0, 0),
      cmd_item(smm_pkg::CMD_UNMAP, 0, 0, 0, 0),
      cmd_item(smm_pkg::CMD_UNMAP, 63, 0, 0, 0),
      cmd_item(smm_pkg::CMD_LOAD, 63, 0, 0, 0),
      cmd_item(smm_pkg::CMD_STORE, 0, 5, 32'ha5a5_a5a5, 0),
      cmd_item(smm_pkg::CMD_LDPROG, 0, 5, 0, 0),
      cmd_item(smm_pkg::CMD_FETCH, 0, 0, 0, 0),
      cmd_item(smm_pkg::CMD_LDPROG, 2, 255, 0, 0),
      cmd_item(smm_pkg::CMD_FETCH, 0, 0, 0, 0),
      cmd_item(smm_pkg::CMD_FETCH, 0, 0, 0, 0),
      cmd_item(smm_pkg::CMD_UNMAP, 1, 0, 0, 0),
      cmd_item(smm_pkg::CMD_MAP, 0, 0, 0, 3),
      cmd_item(smm_pkg::CMD_STORE, 1, 2, 32'h1234_5678, 0),
      cmd_item(3'd6, 0, 0, 0, 0),
      cmd_item(3'd7, 63, 255, 32'hffff_ffff, 511),
      cmd_item(smm_pkg::CMD_LDPROG, 1, 2, 0, 0),
      cmd_item(smm_pkg::CMD_FETCH, 0, 0, 0, 0)
    };
    repeat (7) @(posedge clk);
    rst <= 0;
    foreach (directed[k]) send(directed[k]);
    n_directed = n_sent;
    // A burst of maps part-way through runs the identifiers out.
    for (int n = 0; n < RANDOM_ITEMS; n++) send(rand_request(n >= 400 && n < 470));
    req_valid <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d requests sent (%0d directed), %0d results checked.",
             n_sent, n_directed, checked);
    $display("Receiver held off once for %0d cycles to back up the input.", LONG_HOLD);
    if (fails == 0 && outstanding == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int cyc, run, p;
    cyc = 0;
    run = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 2500) begin
        res_stall <= 1;
        repeat (LONG_HOLD) @(posedge clk);
        res_stall <= 0;
        run = 0;
      end else if (run > 0) run--;
      else if ((cyc / 300) % 4 == 0) res_stall <= 0;
      else begin
        p = $urandom_range(0, 99);
        res_stall <= (p >= 55);
        run = (p < 90) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/smm_pkg.sv
rtl/smm_word_ram.sv
rtl/segmented_memory_manager.sv
bench/smm_checker.sv
bench/tb_top.sv
